// ----- src/pcgbr_pkg.sv -----
// Package for the PCG32 bounded random generator: LCG constants, opcodes,
// and the XSH-RR output permutation. No dependencies.
`default_nettype none

package pcgbr_pkg;

  localparam logic [63:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] LCG_INC  = 64'h1405_7B7E_F767_814F;

  localparam int XSH_SHIFT  = 18;
  localparam int XSH_DROP   = 27;
  localparam int ROT_SHIFT  = 59;
  localparam int FRAC_BITS  = 23;
  localparam int FRAC_DROP  = 32 - FRAC_BITS;

  typedef enum logic [2:0] {
    OP_RAW    = 3'd0,
    OP_RANGE  = 3'd1,
    OP_FRAC   = 3'd2,
    OP_CHANCE = 3'd3,
    OP_RESEED = 3'd4
  } opcode_t;

  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] mixed;
    logic [31:0] x;
    logic [4:0]  r;
    logic [63:0] dbl;
    mixed = (s ^ (s >> XSH_SHIFT)) >> XSH_DROP;
    x     = mixed[31:0];
    r     = s[63:ROT_SHIFT];
    dbl   = {x, x} >> r;
    return dbl[31:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/pcgbr_if.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on nothing.
`default_nettype none

interface pcgbr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] range_low;
  logic [31:0] range_high;
  logic [32:0] threshold;

  modport source (output valid, output opcode, output range_low, output range_high,
                  output threshold, input ready);
  modport sink (input valid, input opcode, input range_low, input range_high,
                input threshold, output ready);
endinterface

interface pcgbr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        hit;

  modport source (output valid, output value, output hit, input ready);
  modport sink (input valid, input value, input hit, output ready);
endinterface

`default_nettype wire

// ----- src/pcgbr_mul.sv -----
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// No dependencies.
`default_nettype none

module pcgbr_mul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [63:0]      p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= {32'd0, a} * {32'd0, b};
    end
  end

endmodule

`default_nettype wire

// ----- src/pcgbr_rem.sv -----
// Bit-serial remainder unit: (2^32 - n) mod n, one quotient bit per cycle.
// No dependencies.
`default_nettype none

module pcgbr_rem (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      result
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [31:0] dsr;
  logic [32:0] trial;
  logic [32:0] diff;
  logic [31:0] result_next;

  always_comb begin
    trial = {result, dvd[31]};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      result_next = diff[31:0];
    end else begin
      result_next = trial[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= 5'd31;
        dvd    <= 32'd0 - divisor;
        dsr    <= divisor;
        result <= '0;
      end else if (busy) begin
        result <= result_next;
        dvd    <= dvd << 1;
        cnt    <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/pcg32_bounded_random_generator_top.sv -----
// PCG32 generator with Lemire bounded range, fraction and chance requests.
// Depends on pcgbr_pkg, pcgbr_if, pcgbr_mul, pcgbr_rem.
//
//   channel   dir  handshake       payload
//   req       in   valid/ready     opcode, range_low, range_high, threshold
//   rsp       out  valid/ready     value, hit
//   seed      in   seed_we         seed_data (64-bit seed register)
//
// A draw uses the shared 32x32 multiplier in S_MUL0 to S_MUL3 (three partial
// products for the 64-bit state, then word * span for a range request).
// Raw, fraction, chance and reseed go from S_MUL3 to S_DONE for the response;
// range passes S_RANGE, a rejection waits once in S_REMW (serial remainder),
// and each redraw returns to S_MUL0. Unknown opcodes go straight to S_DONE.
// Reset (rst, synchronous) clears the state and seed to zero.
// req.ready is high only when idle; a held response stalls the next finish.
`default_nettype none

module pcg32_bounded_random_generator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  pcgbr_req_if.sink        req,
  pcgbr_rsp_if.source      rsp,
  input  wire logic        seed_we,
  input  wire logic [63:0] seed_data
);

  localparam int FRAC_W = pcgbr_pkg::FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_RANGE, S_REMW, S_DONE
  } fsm_t;

  fsm_t        fsm;
  logic [63:0] seed_value;
  logic [63:0] lcg_state;
  logic [63:0] acc;
  logic [2:0]  op;
  logic [31:0] low;
  logic [31:0] span;
  logic [32:0] thr;
  logic [31:0] word;
  logic [31:0] rval;
  logic [31:0] rej_t;
  logic        rej_tv;

  logic        out_valid;
  logic [31:0] out_value;
  logic        out_hit;

  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic        rem_start;
  logic        rem_done;
  logic [31:0] rem_result;

  logic [31:0] value_next;
  logic        hit_next;
  logic [31:0] frac;

  pcgbr_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  pcgbr_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .divisor (span),
    .done    (rem_done),
    .result  (rem_result)
  );

  always_comb begin
    mul_en = 1'b1;
    mul_a  = lcg_state[31:0];
    mul_b  = pcgbr_pkg::LCG_MULT[31:0];
    case (fsm)
      S_MUL0: begin
        mul_a = lcg_state[31:0];
        mul_b = pcgbr_pkg::LCG_MULT[31:0];
      end
      S_MUL1: begin
        mul_a = lcg_state[63:32];
        mul_b = pcgbr_pkg::LCG_MULT[31:0];
      end
      S_MUL2: begin
        mul_a = lcg_state[31:0];
        mul_b = pcgbr_pkg::LCG_MULT[63:32];
      end
      S_MUL3: begin
        mul_a = word;
        mul_b = span;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign rem_start = (fsm == S_RANGE) && (span != 32'd0) && (mul_p[31:0] < span)
                     && !rej_tv;

  always_comb begin
    frac       = word >> pcgbr_pkg::FRAC_DROP;
    value_next = '0;
    hit_next   = 1'b0;
    case (op)
      pcgbr_pkg::OP_RAW:   value_next = word;
      pcgbr_pkg::OP_RANGE: value_next = rval;
      pcgbr_pkg::OP_FRAC:  value_next = frac;
      pcgbr_pkg::OP_CHANCE: begin
        value_next = frac;
        hit_next   = {1'b0, frac[FRAC_W-1:0], {pcgbr_pkg::FRAC_DROP{1'b0}}} < thr;
      end
      default: value_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
    end else if (seed_we) begin
      seed_value <= seed_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      lcg_state <= '0;
      out_valid <= 1'b0;
      rej_tv    <= 1'b0;
    end else begin
      if (rsp.ready && fsm != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (req.valid) begin
            op     <= req.opcode;
            low    <= req.range_low;
            span   <= req.range_high - req.range_low;
            thr    <= req.threshold;
            rej_tv <= 1'b0;
            case (req.opcode)
              pcgbr_pkg::OP_RAW, pcgbr_pkg::OP_RANGE, pcgbr_pkg::OP_FRAC,
              pcgbr_pkg::OP_CHANCE: fsm <= S_MUL0;
              pcgbr_pkg::OP_RESEED: begin
                lcg_state <= seed_value;
                fsm       <= S_MUL0;
              end
              default: fsm <= S_DONE;
            endcase
          end
        end
        S_MUL0: begin
          word <= pcgbr_pkg::xsh_rr(lcg_state);
          fsm  <= S_MUL1;
        end
        S_MUL1: begin
          acc <= mul_p + pcgbr_pkg::LCG_INC;
          fsm <= S_MUL2;
        end
        S_MUL2: begin
          acc[63:32] <= acc[63:32] + mul_p[31:0];
          fsm        <= S_MUL3;
        end
        S_MUL3: begin
          lcg_state <= {acc[63:32] + mul_p[31:0], acc[31:0]};
          if (op == pcgbr_pkg::OP_RANGE) begin
            fsm <= S_RANGE;
          end else begin
            fsm <= S_DONE;
          end
        end
        S_RANGE: begin
          if (span == 32'd0 || mul_p[31:0] >= span) begin
            rval <= low + mul_p[63:32];
            fsm  <= S_DONE;
          end else if (!rej_tv) begin
            fsm <= S_REMW;
          end else if (mul_p[31:0] < rej_t) begin
            fsm <= S_MUL0;
          end else begin
            rval <= low + mul_p[63:32];
            fsm  <= S_DONE;
          end
        end
        S_REMW: begin
          if (rem_done) begin
            rej_t  <= rem_result;
            rej_tv <= 1'b1;
            if (mul_p[31:0] < rem_result) begin
              fsm <= S_MUL0;
            end else begin
              rval <= low + mul_p[63:32];
              fsm  <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_value <= value_next;
            out_hit   <= hit_next;
            fsm       <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

  assign req.ready = (fsm == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.value = out_value;
  assign rsp.hit   = out_hit;

  a_rem_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> fsm == S_REMW)
    else $error("remainder finished outside its wait state");

  a_zero_span_done: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_RANGE && span == 32'd0) |=> fsm == S_DONE)
    else $error("zero span did not finish after one draw");

  a_reseed_load: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.opcode == pcgbr_pkg::OP_RESEED)
      |=> lcg_state == $past(seed_value))
    else $error("reseed did not load the seed register");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_MUL0) |=> !req.ready)
    else $error("ready raised during a draw");

endmodule

`default_nettype wire
